FILE: src/largest_empty_square_finder_unit_defines.svh
// Assertion helpers for the RTL that checks itself.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_UNIT_DEFINES_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_UNIT_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define LESF_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check a condition in the cycle after a trigger.
`define LESF_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: src/lesf_pkg.sv
package lesf_pkg;

    localparam int CHAR_W       = 8;
    localparam int COL_COUNT_W  = 11;
    localparam int SIZE_W       = 11;
    localparam int POS_W        = 10;

    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    localparam logic [SIZE_W-1:0]      SIZE_CAP         = 11'd2047;
    localparam logic [COL_COUNT_W-1:0] COL_COUNT_RESET  = 11'd1024;
    localparam logic [CHAR_W-1:0]      EMPTY_CHAR_RESET = 8'd46;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CHAR   = 1'd1;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic              found;
        logic [SIZE_W-1:0] size;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        logic       full;
    } queue_stat_t;

endpackage

FILE: src/lesf_line_buf.sv
module lesf_line_buf #(
    parameter int MAX_COLS = lesf_pkg::DEF_MAX_COLS
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             rd_en,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] rd_addr,
    output logic [lesf_pkg::SIZE_W-1:0]                      rd_data,
    input  logic                                             wr_en,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] wr_addr,
    input  logic [lesf_pkg::SIZE_W-1:0]                      wr_data
);
    import lesf_pkg::*;

    logic [SIZE_W-1:0] mem [MAX_COLS];
    logic [SIZE_W-1:0] rd_data_reg;
    logic [SIZE_W-1:0] fwd_data_reg;
    logic              fwd_hit_reg;
    logic              fwd_hit_next;

    assign fwd_hit_next = rd_en && wr_en && (rd_addr == wr_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        fwd_data_reg <= wr_data;
    end

    // Same-entry write and read in one cycle: take the new word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

FILE: src/lesf_scan.sv
module lesf_scan #(
    parameter int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             accept,
    input  logic                                             last,
    input  logic [lesf_pkg::COL_COUNT_W-1:0]                 column_count,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] col_cur,
    output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] row_cur
);
    import lesf_pkg::*;

    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam int CMP_W = (CNT_W > COL_COUNT_W) ? CNT_W : COL_COUNT_W;
    localparam logic [RW-1:0] ROW_TOP = RW'(MAX_ROWS - 1);

    logic [CW-1:0]    col_reg, col_next, col_adv;
    logic [RW-1:0]    row_reg, row_next, row_adv;
    logic [CMP_W-1:0] cols, count_ext, col_inc;
    logic             wrap_in;

    always_comb begin
        count_ext = CMP_W'(column_count);
        if (column_count == '0) begin
            cols = CMP_W'(1);
        end else if (count_ext > CMP_W'(MAX_COLS)) begin
            cols = CMP_W'(MAX_COLS);
        end else begin
            cols = count_ext;
        end

        // Column count lowered mid-map: start the next row now.
        wrap_in = CMP_W'(col_reg) >= cols;
        col_cur = wrap_in ? '0 : col_reg;
        if (wrap_in && row_reg != ROW_TOP) begin
            row_cur = row_reg + 1'b1;
        end else begin
            row_cur = row_reg;
        end

        col_inc = CMP_W'(col_cur) + 1'b1;
        if (col_inc >= cols) begin
            col_adv = '0;
            row_adv = (row_cur != ROW_TOP) ? row_cur + 1'b1 : row_cur;
        end else begin
            col_adv = col_inc[CW-1:0];
            row_adv = row_cur;
        end

        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            col_next = last ? '0 : col_adv;
            row_next = last ? '0 : row_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: src/lesf_dp.sv
module lesf_dp #(
    parameter int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             in_accept,
    input  logic                                             in_empty,
    input  logic                                             in_last,
    input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] in_col,
    input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] in_row,
    input  logic [lesf_pkg::SIZE_W-1:0]                      up,
    output logic                                             wr_en,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] wr_addr,
    output logic [lesf_pkg::SIZE_W-1:0]                      wr_data,
    output logic                                             res_valid,
    output lesf_pkg::result_t                                res
);
    import lesf_pkg::*;

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic              s1_valid_reg, s1_empty_reg, s1_last_reg;
    logic [CW-1:0]     s1_col_reg;
    logic [RW-1:0]     s1_row_reg;
    logic [SIZE_W-1:0] left_reg, diag_reg, best_size_reg;
    logic [SIZE_W-1:0] left_next, diag_next, best_size_next;
    logic [RW-1:0]     best_row_reg, best_row_next;
    logic [CW-1:0]     best_col_reg, best_col_next;
    logic [SIZE_W-1:0] min_val, size;
    logic [SIZE_W-1:0] best_size_cur;
    logic [RW-1:0]     best_row_cur;
    logic [CW-1:0]     best_col_cur;
    logic              better;

    always_ff @(posedge aclk) begin
        s1_empty_reg <= in_empty;
        s1_last_reg  <= in_last;
        s1_col_reg   <= in_col;
        s1_row_reg   <= in_row;
    end

    always_comb begin
        min_val = up;
        if (diag_reg < min_val) begin
            min_val = diag_reg;
        end
        if (left_reg < min_val) begin
            min_val = left_reg;
        end

        if (!s1_empty_reg) begin
            size = '0;
        end else if (s1_row_reg == '0 || s1_col_reg == '0) begin
            size = SIZE_W'(1);
        end else if (min_val == SIZE_CAP) begin
            size = SIZE_CAP;
        end else begin
            size = min_val + 1'b1;
        end

        // Strict test: the first corner in scan order keeps the title.
        better        = size > best_size_reg;
        best_size_cur = better ? size : best_size_reg;
        best_row_cur  = better ? s1_row_reg : best_row_reg;
        best_col_cur  = better ? s1_col_reg : best_col_reg;

        left_next      = left_reg;
        diag_next      = diag_reg;
        best_size_next = best_size_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        if (s1_valid_reg) begin
            if (s1_last_reg) begin
                left_next      = '0;
                diag_next      = '0;
                best_size_next = '0;
                best_row_next  = '0;
                best_col_next  = '0;
            end else begin
                left_next      = size;
                diag_next      = up;
                best_size_next = best_size_cur;
                best_row_next  = best_row_cur;
                best_col_next  = best_col_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            left_reg      <= '0;
            diag_reg      <= '0;
            best_size_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
        end else begin
            s1_valid_reg  <= in_accept;
            left_reg      <= left_next;
            diag_reg      <= diag_next;
            best_size_reg <= best_size_next;
            best_row_reg  <= best_row_next;
            best_col_reg  <= best_col_next;
        end
    end

    assign wr_en     = s1_valid_reg;
    assign wr_addr   = s1_col_reg;
    assign wr_data   = size;
    assign res_valid = s1_valid_reg && s1_last_reg;

    always_comb begin
        res.found = best_size_cur != '0;
        res.size  = best_size_cur;
        res.row   = POS_W'(best_row_cur);
        res.col   = POS_W'(best_col_cur);
    end

endmodule

FILE: src/lesf_out_queue.sv
module lesf_out_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  lesf_pkg::result_t     push_data,
    input  logic                  pop,
    output logic                  out_valid,
    output lesf_pkg::result_t     out_data,
    output lesf_pkg::queue_stat_t stat
);
    import lesf_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign do_pop  = pop && (count_reg != 2'd0);
    assign do_push = push;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid  = count_reg != 2'd0;
    assign out_data   = entry_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = count_reg == 2'd2;

endmodule

FILE: src/largest_empty_square_finder_unit.sv
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata = cell_char, s_tlast = last_cell
// m_        out  m_tvalid/m_tready    m_tdata = size/row/col, m_tuser = found
// cfg_      in   cfg_valid/cfg_ready  cfg_index selects register, cfg_data
//
// One map cell per cycle while s_tready is high: a cell reads its upper size
// from the line buffer (synchronous read) and is resolved and written back in the next.
// A result word passes the s1 registers and the output queue on its way to m_; a two-word
// queue holds results, and s_tready drops only while the queue, counting the
// result entering and the word leaving at this edge, would still hold two.
// Reset (aresetn low, synchronous) clears counters, best square and config
// to its defaults; the line buffer is not cleared.
`include "largest_empty_square_finder_unit_defines.svh"

module largest_empty_square_finder_unit #(
    parameter int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Cell stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lesf_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] cell_char
    input  logic                                s_tlast,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [10:0] square_size, [20:11] corner_row, [30:21] corner_col, [31] zero
    output logic [lesf_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tuser,   // [0] found
    // Register writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lesf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lesf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lesf_pkg::*;

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [COL_COUNT_W-1:0] column_count_reg;
    logic [CHAR_W-1:0]      empty_char_reg;
    logic                   s_accept, m_pop;
    logic [CW-1:0]          col_cur, wr_addr;
    logic [RW-1:0]          row_cur;
    logic [SIZE_W-1:0]      up, wr_data;
    logic                   wr_en;
    logic                   res_valid;
    logic [1:0]             q_level;
    result_t                res, out_res;
    queue_stat_t            q_stat;

    // Registers must be written only while the block is idle; unchecked, all are taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= COL_COUNT_RESET;
            empty_char_reg   <= EMPTY_CHAR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                REG_EMPTY_CHAR:   empty_char_reg   <= cfg_data[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // Queue level after this edge; hold input unless one more result still fits.
    assign q_level  = q_stat.count + {1'b0, res_valid} - {1'b0, m_pop};
    assign s_tready = q_level <= 2'd1;
    assign s_accept = s_tvalid && s_tready;
    assign m_pop    = m_tvalid && m_tready;

    lesf_scan #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .last         (s_tlast),
        .column_count (column_count_reg),
        .col_cur      (col_cur),
        .row_cur      (row_cur)
    );

    lesf_line_buf #(
        .MAX_COLS (MAX_COLS)
    ) u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (col_cur),
        .rd_data (up),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lesf_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_accept),
        .in_empty  (s_tdata[CHAR_W-1:0] == empty_char_reg),
        .in_last   (s_tlast),
        .in_col    (col_cur),
        .in_row    (row_cur),
        .up        (up),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_valid (res_valid),
        .res       (res)
    );

    lesf_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .pop       (m_pop),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .stat      (q_stat)
    );

    // Pack the result word, lowest field first.
    assign m_tdata = {1'b0, out_res.col, out_res.row, out_res.size};
    assign m_tuser = out_res.found;

    // A result never arrives at a full queue unless a word leaves in the same cycle.
    `LESF_ASSERT_NOW(a_queue_no_overflow, !res_valid || !q_stat.full || m_pop, "result queue overflow")
    // found flag agrees with a nonzero size.
    `LESF_ASSERT_NOW(a_found_matches_size, !m_tvalid || (m_tuser == (m_tdata[10:0] != 11'd0)), "found flag mismatch")
    // A last cell restarts the scan at the top-left corner.
    `LESF_ASSERT_NEXT(a_restart_after_last, s_accept && s_tlast, (col_cur == '0) && (row_cur == '0), "scan did not restart")

endmodule

FILE: tb/largest_empty_square_finder_unit_test.sv
module largest_empty_square_finder_unit_test;
    import lesf_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 400;     // receiver hold-off for the full-queue stall
    localparam int RANDOM_CELLS   = 300;
    localparam int PRIME_CELLS    = 80;
    localparam int TIMEOUT_CYCLES = 400_000;

    // Mirror of the block: configuration, line buffer, running square and the
    // result words still owed by the block.
    class square_scoreboard;
        logic [COL_COUNT_W-1:0] column_count;
        logic [CHAR_W-1:0]      empty_char;
        logic [SIZE_W-1:0]      row_sizes [DEF_MAX_COLS];
        logic [SIZE_W-1:0]      left_size, diag_size, best_size;
        logic [POS_W-1:0]       row_idx, best_row, best_col;
        logic [COL_COUNT_W-1:0] col_idx;
        result_t                squares_due [$];
        int cells_seen = 0;
        int maps_seen = 0;
        int results_seen = 0;
        int failures = 0;

        function new();
            column_count = COL_COUNT_RESET;
            empty_char   = EMPTY_CHAR_RESET;
            foreach (row_sizes[i]) row_sizes[i] = '0;
            restart();
        endfunction

        function void restart();
            left_size = '0;
            diag_size = '0;
            row_idx   = '0;
            col_idx   = '0;
            best_size = '0;
            best_row  = '0;
            best_col  = '0;
        endfunction

        function void wrap_row();
            col_idx = '0;
            if (row_idx < DEF_MAX_ROWS - 1) row_idx++;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_COLUMN_COUNT: column_count = data;
                REG_EMPTY_CHAR:   empty_char   = data[CHAR_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the square sizes by one accepted cell.
        function void note_cell(logic [CHAR_W-1:0] ch, logic last);
            logic [COL_COUNT_W-1:0] cols;
            logic [SIZE_W-1:0]      up, least, sz;
            result_t                due;
            if (column_count == '0)
                cols = 1;
            else if (column_count > DEF_MAX_COLS)
                cols = COL_COUNT_W'(DEF_MAX_COLS);
            else
                cols = column_count;
            cells_seen++;
            if (col_idx >= cols) wrap_row();
            up = row_sizes[col_idx];
            sz = '0;
            if (ch == empty_char) begin
                if (row_idx == '0 || col_idx == '0) begin
                    sz = 1;
                end else begin
                    least = up;
                    if (diag_size < least) least = diag_size;
                    if (left_size < least) least = left_size;
                    sz = (least >= SIZE_CAP) ? SIZE_CAP : least + 1'b1;
                end
            end
            if (sz > best_size) begin
                best_size = sz;
                best_row  = row_idx;
                best_col  = col_idx[POS_W-1:0];
            end
            row_sizes[col_idx] = sz;
            diag_size = up;
            left_size = sz;
            col_idx++;
            if (col_idx >= cols) wrap_row();
            if (last) begin
                due.found = (best_size != '0);
                due.size  = best_size;
                due.row   = best_row;
                due.col   = best_col;
                squares_due.push_back(due);
                maps_seen++;
                restart();
            end
        endfunction

        function void compare_field(string name, logic [SIZE_W-1:0] want,
                                    logic [SIZE_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (squares_due.size() == 0) begin
                $error("result word with none expected: found %0d size %0d row %0d col %0d",
                       got.found, got.size, got.row, got.col);
                failures++;
                return;
            end
            want = squares_due.pop_front();
            compare_field("found", SIZE_W'(want.found), SIZE_W'(got.found));
            compare_field("square_size", want.size, got.size);
            compare_field("corner_row", SIZE_W'(want.row), SIZE_W'(got.row));
            compare_field("corner_col", SIZE_W'(want.col), SIZE_W'(got.col));
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;     // [7:0] cell_char
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;            // [10:0] size, [20:11] row, [30:21] col
    logic                   m_tuser;            // [0] found
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    square_scoreboard grid;
    bit quiet         = 1'b0;   // no idling on either side
    bit sender_calm   = 1'b0;   // no idling on the cell side for the current map
    int hold_requests = 0;
    int holds_served  = 0;
    int cfg_writes    = 0;

    largest_empty_square_finder_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // Offer one cell word, at times after a random gap, and hold it until taken.
    // Leave s_tvalid high afterwards so back-to-back words never drop it.
    task automatic push_cell(input logic [CHAR_W-1:0] ch, input logic last);
        if (!quiet && !sender_calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        grid.note_cell(ch, last);
    endtask

    // Drop the cell stream, wait for every owed result, then let the pipe drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (grid.squares_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        grid.set_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic write_config(input bit set_cols, input logic [COL_COUNT_W-1:0] cols,
                                input bit set_char, input logic [CHAR_W-1:0] ch);
        settle();
        if (set_cols) put_reg(REG_COLUMN_COUNT, cols);
        if (set_char) put_reg(REG_EMPTY_CHAR, CFG_DATA_W'(ch));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] pick_char(int empty_pct);
        logic [CHAR_W-1:0] ch;
        if ($urandom_range(0, 99) < empty_pct) return grid.empty_char;
        ch = $urandom_range(0, 255);
        if (ch == grid.empty_char) ch = ~ch;
        return ch;
    endfunction

    // Send one map of n cells; optionally change the column count after split_at cells.
    task automatic feed_map(input int n, input int empty_pct, input int split_at,
                            input logic [COL_COUNT_W-1:0] split_cols);
        for (int i = 0; i < n; i++) begin
            if (split_at != 0 && i == split_at) write_config(1'b1, split_cols, 1'b0, '0);
            push_cell(pick_char(empty_pct), i == n - 1);
        end
    endtask

    // Sample one edge on the result side and check the word if it moved.
    task automatic sink_edge();
        result_t got;
        @(posedge aclk);
        if (m_tvalid && m_tready) begin
            got.found = m_tuser;
            got.size  = m_tdata[SIZE_W-1:0];
            got.row   = m_tdata[SIZE_W +: POS_W];
            got.col   = m_tdata[SIZE_W + POS_W +: POS_W];
            grid.check_result(got);
        end
    endtask

    // Result side: random stalls, calm stretches, and the long hold-off on request.
    initial begin : result_sink
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (holds_served != hold_requests) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) sink_edge();
            end else if (!quiet && $urandom_range(0, 39) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) sink_edge();
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) sink_edge();
            end else begin
                m_tready <= 1'b1;
                sink_edge();
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Verification failed");
        $finish;
    end

    initial begin : cell_source
        int random_cells;
        int n, span, split_at, r;
        logic [COL_COUNT_W-1:0] cols, eff, split_cols;
        logic [CHAR_W-1:0] new_char;
        bit set_char;
        bit pressure_done;

        grid = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Prime the line buffer: the leading entries of one row at the reset
        // settings, wider than any row that later runs past its first line, so
        // every later row reads only entries already written.
        feed_map(PRIME_CELLS, 92, 0, '0);

        // Count 0 acts as 1; empty code 0; several empties, first corner wins.
        write_config(1'b1, '0, 1'b1, 8'h00);
        push_cell(8'h00, 1'b0);
        push_cell(8'h00, 1'b0);
        push_cell(8'hFF, 1'b1);
        // No empty cell at all: found stays low and the corner reads zero.
        write_config(1'b1, 11'd3, 1'b1, 8'hFF);
        push_cell(8'h00, 1'b0);
        push_cell(8'h7F, 1'b0);
        push_cell(8'h80, 1'b0);
        push_cell(8'hFE, 1'b1);
        // Fully empty 3x3 map: square of three in the far corner.
        for (int i = 0; i < 9; i++) push_cell(8'hFF, i == 8);
        // Shrink the row mid-map past the current column: next cell starts a new row.
        write_config(1'b1, 11'd4, 1'b0, '0);
        for (int i = 0; i < 3; i++) push_cell(8'hFF, 1'b0);
        write_config(1'b1, 11'd2, 1'b0, '0);
        for (int i = 0; i < 3; i++) push_cell(8'hFF, i == 2);
        // Map of a single cell.
        push_cell(8'hFF, 1'b1);

        // Counts above the maximum clamp to it; keep the map short.
        write_config(1'b1, 11'd2047, 1'b1, 8'h2E);
        feed_map(50, 85, 0, '0);

        // Overrun the row counter: one column, first empty cell past row 1023.
        write_config(1'b1, 11'd1, 1'b0, '0);
        for (int i = 0; i < 1030; i++) push_cell(pick_char(i < 1026 ? 0 : 100), i == 1029);

        random_cells  = 0;
        pressure_done = 1'b0;
        while (random_cells < RANDOM_CELLS) begin
            if (random_cells >= RANDOM_CELLS - 120) quiet = 1'b1;
            if (!pressure_done && random_cells >= 100) begin
                // Hold off the receiver and keep pushing one-cell maps until the
                // result queue fills and the cell side stalls.
                pressure_done = 1'b1;
                sender_calm   = 1'b1;
                hold_requests++;
                for (int i = 0; i < 24; i++) push_cell(pick_char(50), 1'b1);
                random_cells += 24;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70)      cols = $urandom_range(1, 8);
                else if (r < 88) cols = $urandom_range(9, 40);
                else if (r < 94) cols = '0;
                else if (r < 97) cols = $urandom_range(1025, 2047);
                else             cols = 11'd1024;
                eff = (cols == '0) ? 11'd1 : (cols > DEF_MAX_COLS) ? 11'd1024 : cols;

                r = $urandom_range(0, 99);
                set_char = (r >= 60);
                if (r < 70)      new_char = 8'h00;
                else if (r < 80) new_char = 8'hFF;
                else             new_char = $urandom_range(0, 255);
                write_config(1'b1, cols, set_char, new_char);

                span = int'(eff) * (int'(eff) + 2);
                if (span > 80) span = 80;
                if (span < 20) span = 20;
                n = $urandom_range(1, span);
                split_at   = 0;
                split_cols = '0;
                if (n >= 4 && $urandom_range(0, 5) == 0) begin
                    split_at   = $urandom_range(1, n - 1);
                    split_cols = $urandom_range(0, 12);
                end
                sender_calm = ($urandom_range(0, 3) == 0);
                feed_map(n, $urandom_range(55, 97), split_at, split_cols);
                random_cells += n;
            end
        end

        // Drain: wait for every owed word, then watch a while for strays.
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (grid.squares_due.size() != 0);
        repeat (4 * SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d cells in %0d maps, %0d register writes, %0d result words.",
                 grid.cells_seen, grid.maps_seen, cfg_writes, grid.results_seen);
        $display("Widths 0 to 2047 incl. mid-map changes, row overrun, full-queue stall.");
        if (grid.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/lesf_pkg.sv
src/lesf_line_buf.sv
src/lesf_scan.sv
src/lesf_dp.sv
src/lesf_out_queue.sv
src/largest_empty_square_finder_unit.sv
tb/largest_empty_square_finder_unit_test.sv
